>>> hw/rtl/area_average_downscale_assert.svh
// assertion macros for the area average downscaler
// used by the top level only
`ifndef AREA_AVERAGE_DOWNSCALE_ASSERT_SVH
`define AREA_AVERAGE_DOWNSCALE_ASSERT_SVH
// implication checked on every clock, off during reset
`define AAD_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle implication
`define AAD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

>>> hw/rtl/aad_pkg.sv
// shared constants and types for the area average downscaler
// no dependencies
package aad_pkg;
    localparam int MaxGrid   = 64;
    localparam int MaxSource = 1024;
    localparam int SumW      = 28;
    localparam int DimW      = 11;
    localparam int SizeW     = 7;
    localparam int CntW      = 21;
    localparam logic [7:0] FullAlpha = 8'd255;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SIZE   = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // finished cell handed from the front end to the divider
    typedef struct packed {
        logic [5:0]      cell_x;
        logic [5:0]      cell_y;
        logic            last;
        logic [CntW-1:0] count;
        logic [SumW-1:0] sum_r;
        logic [SumW-1:0] sum_g;
        logic [SumW-1:0] sum_b;
        logic [SumW-1:0] sum_a;
    } cell_t;
endpackage

>>> hw/rtl/area_average_downscale.sv
// area average downscaler: a pixel beat is taken only after the previous one's read-modify-write
// after a bin closes, input waits as the next bin's end edge steps over its columns (or rows)
// input also waits while a finished cell waits for the divider to take it
// a cell divides a quotient bit a step; its result passes the rmw stage, cell register and divider
// reset: 64x64 source, 16x16 grid, alpha on, origin; input waits while first bin ends are searched
// a config write also restarts the origin and that search; sum memories are never cleared
`include "area_average_downscale_assert.svh"
module area_average_downscale
    import aad_pkg::*;
#(
    parameter int MAX_GRID   = MaxGrid,
    parameter int MAX_SOURCE = MaxSource
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, alpha
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cell_x, cell_y, red_avg, green_avg, blue_avg, alpha_avg
    output logic        m_tlast,   // last_of_frame
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    localparam int AddrW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int PosW  = $clog2(MAX_SOURCE + 1);
    localparam int NumW  = PosW + $clog2(MAX_GRID + 1);

    // configuration registers
    logic [DimW-1:0]  width_reg, height_reg;
    logic [SizeW-1:0] size_reg;
    logic             alpha_en_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DimW'(64);
            height_reg   <= DimW'(64);
            size_reg     <= SizeW'(16);
            alpha_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg    <= cfg_data;
                REG_HEIGHT: height_reg   <= cfg_data;
                REG_SIZE:   size_reg     <= cfg_data[SizeW-1:0];
                REG_ALPHA:  alpha_en_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // effective dimensions
    logic [PosW-1:0]  w_eff, h_eff;
    logic [SizeW+1:0] n_eff;
    always_comb
    begin
        w_eff = (width_reg == '0) ? PosW'(1) :
                (32'(width_reg) > MAX_SOURCE) ? PosW'(MAX_SOURCE) : PosW'(width_reg);
        h_eff = (height_reg == '0) ? PosW'(1) :
                (32'(height_reg) > MAX_SOURCE) ? PosW'(MAX_SOURCE) : PosW'(height_reg);
        n_eff = (size_reg == '0) ? (SizeW+2)'(1) :
                (32'(size_reg) > MAX_GRID) ? (SizeW+2)'(MAX_GRID) : (SizeW+2)'(size_reg);
        if (32'(n_eff) > 32'(w_eff)) n_eff = (SizeW+2)'(w_eff);
        if (32'(n_eff) > 32'(h_eff)) n_eff = (SizeW+2)'(h_eff);
    end

    // position state; bin edges are tracked as integer end positions
    logic [PosW-1:0] scol_reg, srow_reg;
    logic [7:0]      gcol_reg, grow_reg;
    logic [NumW-1:0] cnum_reg, rnum_reg;     // x*W, y*H
    logic [NumW-1:0] cacc_reg, racc_reg;     // (edge)*N, running multiple of N
    logic [PosW-1:0] cstart_reg, cend_reg, rstart_reg, rend_reg;

    // pixel pipeline: capture beat, then read-modify-write
    logic            p1_reg;
    logic [31:0]     pix_reg;
    logic [AddrW-1:0] idx_reg;
    logic            band_reg, emit_reg, last_reg;
    logic [5:0]      ex_reg, ey_reg;
    logic [CntW-1:0] cnt_reg;
    logic            cell_valid_reg;
    cell_t           cell_reg;
    logic            div_ready;

    // first bin end after restart: smallest e with (e+1)*N > W
    logic [PosW-1:0] fend_c, fend_r;
    logic            need_init_reg;
    logic [PosW-1:0] ic_reg, ir_reg;
    logic [NumW-1:0] ica_reg, ira_reg;
    logic            init_busy_reg;

    // step unit: advance end edge until (end+1)*N > num+W, one step a cycle except in an rmw beat
    assign fend_c = ic_reg;
    assign fend_r = ir_reg;

    // edges for current column and row after a frame start
    logic            fs;
    logic [PosW-1:0] sc, sr, ce, cs, re, rs;
    logic [7:0]      gc, gr;
    logic [NumW-1:0] cn, rn;
    always_comb
    begin
        fs = s_tuser;
        sc = fs ? '0 : scol_reg;
        sr = fs ? '0 : srow_reg;
        gc = fs ? '0 : gcol_reg;
        gr = fs ? '0 : grow_reg;
        cn = fs ? '0 : cnum_reg;
        rn = fs ? '0 : rnum_reg;
        cs = fs ? '0 : cstart_reg;
        rs = fs ? '0 : rstart_reg;
        ce = fs ? fend_c : cend_reg;
        re = fs ? fend_r : rend_reg;
    end

    // edge search: column and row end edges keep advancing while (end+1)*N <= num+W
    logic            busy_c, busy_r;
    assign busy_c = (32'(cacc_reg) + 32'(n_eff)) <= (32'(cnum_reg) + 32'(w_eff));
    assign busy_r = (32'(racc_reg) + 32'(n_eff)) <= (32'(rnum_reg) + 32'(h_eff));

    // input waits for the rmw beat, the first bin end search, a pending edge search and a waiting cell
    logic accept;
    assign s_tready = !p1_reg && !init_busy_reg && !cell_valid_reg && !busy_c && !busy_r;
    assign accept   = s_tvalid && s_tready;

    // wrap decisions for the accepted pixel
    logic col_wrap, row_wrap, col_close, row_close;
    always_comb
    begin
        col_close = (sc + 1'b1 == ce);
        row_close = (sr + 1'b1 == re);
        col_wrap  = (32'(sc) + 1 >= 32'(w_eff));
        row_wrap  = (32'(sr) + 1 >= 32'(h_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg <= '0; srow_reg <= '0; gcol_reg <= '0; grow_reg <= '0;
            cnum_reg <= '0; rnum_reg <= '0; cacc_reg <= '0; racc_reg <= '0;
            cstart_reg <= '0; rstart_reg <= '0; cend_reg <= '0; rend_reg <= '0;
            ic_reg <= '0; ir_reg <= '0; ica_reg <= '0; ira_reg <= '0;
            init_busy_reg <= 1'b1;
            need_init_reg <= 1'b1;
            p1_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            scol_reg <= '0; srow_reg <= '0; gcol_reg <= '0; grow_reg <= '0;
            cnum_reg <= '0; rnum_reg <= '0; cacc_reg <= '0; racc_reg <= '0;
            cstart_reg <= '0; rstart_reg <= '0; cend_reg <= '0; rend_reg <= '0;
            ic_reg <= '0; ir_reg <= '0; ica_reg <= '0; ira_reg <= '0;
            init_busy_reg <= 1'b1;
            p1_reg <= 1'b0;
        end
        else if (init_busy_reg)
        begin
            // find first bin ends for a frame restart, then keep them
            if ((32'(ica_reg) + 32'(n_eff)) <= 32'(w_eff))
            begin
                ica_reg <= ica_reg + NumW'(n_eff);
                ic_reg  <= ic_reg + 1'b1;
            end
            if ((32'(ira_reg) + 32'(n_eff)) <= 32'(h_eff))
            begin
                ira_reg <= ira_reg + NumW'(n_eff);
                ir_reg  <= ir_reg + 1'b1;
            end
            if (!((32'(ica_reg) + 32'(n_eff)) <= 32'(w_eff)) &&
                !((32'(ira_reg) + 32'(n_eff)) <= 32'(h_eff)))
            begin
                init_busy_reg <= 1'b0;
                if (need_init_reg || (scol_reg == '0 && srow_reg == '0 &&
                                      cend_reg == '0))
                begin
                    cend_reg <= ic_reg; rend_reg <= ir_reg;
                    cacc_reg <= ica_reg; racc_reg <= ira_reg;
                end
                need_init_reg <= 1'b0;
            end
        end
        else if (p1_reg)
        begin
            p1_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_reg <= 1'b1;
            if (col_wrap)
            begin
                scol_reg <= '0; gcol_reg <= '0; cnum_reg <= '0;
                cstart_reg <= '0; cend_reg <= fend_c; cacc_reg <= ica_reg;
                if (row_wrap)
                begin
                    srow_reg <= '0; grow_reg <= '0; rnum_reg <= '0;
                    rstart_reg <= '0; rend_reg <= fend_r; racc_reg <= ira_reg;
                end
                else
                begin
                    // next source row; a closed row bin starts where the old one ended
                    srow_reg   <= sr + 1'b1;
                    grow_reg   <= row_close ? gr + 1'b1 : gr;
                    rnum_reg   <= row_close ? rn + NumW'(h_eff) : rn;
                    rstart_reg <= row_close ? re : rs;
                    rend_reg   <= re;
                    racc_reg   <= fs ? ira_reg : racc_reg;
                end
            end
            else
            begin
                // next source column; a closed column bin starts where the old one ended
                scol_reg   <= sc + 1'b1;
                gcol_reg   <= col_close ? gc + 1'b1 : gc;
                cnum_reg   <= col_close ? cn + NumW'(w_eff) : cn;
                cstart_reg <= col_close ? ce : cs;
                cend_reg <= ce; cacc_reg <= fs ? ica_reg : cacc_reg;
                srow_reg <= sr; grow_reg <= gr; rnum_reg <= rn;
                rstart_reg <= rs; rend_reg <= re; racc_reg <= fs ? ira_reg : racc_reg;
            end
        end
        else
        begin
            // advance pending end edges one step a cycle
            if (busy_c)
            begin
                cacc_reg <= cacc_reg + NumW'(n_eff);
                cend_reg <= cend_reg + 1'b1;
            end
            if (busy_r)
            begin
                racc_reg <= racc_reg + NumW'(n_eff);
                rend_reg <= rend_reg + 1'b1;
            end
        end
    end

    // capture pixel and decisions for the read-modify-write stage
    always_ff @(posedge clk)
    begin
        if (accept && !p1_reg && !init_busy_reg && !cfg_we)
        begin
            pix_reg  <= {alpha_en_reg ? s_tdata[31:24] : FullAlpha, s_tdata[23:0]};
            idx_reg  <= gc[AddrW-1:0];
            band_reg <= (sr == rs);
            emit_reg <= col_close && row_close;
            ex_reg   <= gc[5:0];
            ey_reg   <= gr[5:0];
            last_reg <= (32'(gc) + 1 == 32'(n_eff)) && (32'(gr) + 1 == 32'(n_eff));
            cnt_reg  <= CntW'((ce - cs) * (re - rs));
        end
    end

    // sum memories, read in the capture cycle and written in the cycle after it
    logic [SumW-1:0] rd [4];
    logic [SumW-1:0] wr [4];
    logic            p1_fire;
    assign p1_fire = p1_reg;
    for (genvar c = 0; c < 4; c++)
    begin : g_sum
        aad_ram #(.Width(SumW), .Depth(MAX_GRID)) u_ram (
            .clk  (clk),
            .we   (p1_fire),
            .waddr(idx_reg),
            .wdata(wr[c]),
            .raddr(gc[AddrW-1:0]),
            .rdata(rd[c])
        );
        assign wr[c] = band_reg ? SumW'(pix_reg[8*c +: 8])
                                : rd[c] + SumW'(pix_reg[8*c +: 8]);
    end

    // finished cell waits here for the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_valid_reg <= 1'b0;
        else if (p1_fire && emit_reg)
            cell_valid_reg <= 1'b1;
        else if (div_ready)
            cell_valid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (p1_fire && emit_reg)
        begin
            cell_reg.cell_x <= ex_reg;
            cell_reg.cell_y <= ey_reg;
            cell_reg.last   <= last_reg;
            cell_reg.count  <= cnt_reg;
            cell_reg.sum_r  <= wr[0];
            cell_reg.sum_g  <= wr[1];
            cell_reg.sum_b  <= wr[2];
            cell_reg.sum_a  <= wr[3];
        end
    end

    logic [7:0] ra, ga, ba, aa;
    logic [5:0] ox, oy;
    aad_divider u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cell_valid_reg),
        .in_ready     (div_ready),
        .in_cell      (cell_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .cell_x       (ox),
        .cell_y       (oy),
        .red_avg      (ra),
        .green_avg    (ga),
        .blue_avg     (ba),
        .alpha_avg    (aa),
        .last_of_frame(m_tlast)
    );
    assign m_tdata = {4'b0000, aa, ba, ga, ra, oy, ox};

    `AAD_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, p1_reg, !accept, "accept during rmw")
    `AAD_ASSERT_NEXT(a_rmw_follows, clk, rst_n, accept && !cfg_we, p1_reg, "rmw missing")
    `AAD_ASSERT_IMPL(a_cell_hold, clk, rst_n, cell_valid_reg && p1_reg, !emit_reg,
                     "cell overrun")
endmodule

>>> hw/rtl/aad_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module aad_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/aad_divider.sv
// sequential restoring divider for four channel sums by one pixel count
// depends on aad_pkg
module aad_divider
    import aad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cell_t       in_cell,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  cell_x,
    output logic [5:0]  cell_y,
    output logic [7:0]  red_avg,
    output logic [7:0]  green_avg,
    output logic [7:0]  blue_avg,
    output logic [7:0]  alpha_avg,
    output logic        last_of_frame
);
    localparam int StepW = $clog2(SumW + 1);

    div_state_t        state_reg, state_next;
    logic [StepW-1:0]  step_reg;
    cell_t             cell_reg;
    logic [SumW-1:0]   quo_reg [4];
    logic [SumW:0]     rem_reg [4];
    logic [SumW-1:0]   num_reg [4];
    logic [SumW:0]     trial   [4];
    logic [SumW:0]     shifted [4];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (in_valid) state_next = DIV_RUN;
            DIV_RUN:  if (step_reg == StepW'(SumW - 1)) state_next = DIV_DONE;
            DIV_DONE: if (out_ready) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == DIV_IDLE);
        out_valid = (state_reg == DIV_DONE);
    end

    // one quotient bit per cycle on each channel
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            shifted[c] = {rem_reg[c][SumW-1:0], num_reg[c][SumW-1]};
            trial[c]   = shifted[c] - {{(SumW + 1 - CntW){1'b0}}, cell_reg.count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_RUN)
                step_reg <= step_reg + 1'b1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && in_valid)
        begin
            cell_reg   <= in_cell;
            num_reg[0] <= in_cell.sum_r;
            num_reg[1] <= in_cell.sum_g;
            num_reg[2] <= in_cell.sum_b;
            num_reg[3] <= in_cell.sum_a;
            for (int c = 0; c < 4; c++)
            begin
                rem_reg[c] <= '0;
                quo_reg[c] <= '0;
            end
        end
        else if (state_reg == DIV_RUN)
        begin
            for (int c = 0; c < 4; c++)
            begin
                num_reg[c] <= {num_reg[c][SumW-2:0], 1'b0};
                if (!trial[c][SumW])
                begin
                    rem_reg[c] <= trial[c];
                    quo_reg[c] <= {quo_reg[c][SumW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= shifted[c];
                    quo_reg[c] <= {quo_reg[c][SumW-2:0], 1'b0};
                end
            end
        end
    end

    assign cell_x        = cell_reg.cell_x;
    assign cell_y        = cell_reg.cell_y;
    assign last_of_frame = cell_reg.last;
    assign red_avg       = quo_reg[0][7:0];
    assign green_avg     = quo_reg[1][7:0];
    assign blue_avg      = quo_reg[2][7:0];
    assign alpha_avg     = quo_reg[3][7:0];
endmodule

>>> verif/testbench.sv
// self-checking testbench for the area average downscaler: pixel beats in, averaged cells out
// depends on aad_pkg and area_average_downscale; carries its own bit-exact cell predictor
module testbench;
    import aad_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } avg_cell_t;

    typedef struct {
        bit         alpha_on;
        bit         fs;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        bit         typed;
    } pixel_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [10:0] cfg_data = '0;

    // predictor state
    logic [10:0] reg_width = 11'd64, reg_height = 11'd64;
    logic [6:0]  reg_grid = 7'd16;
    bit          reg_alpha = 1'b1;
    logic [SumW-1:0] red_acc[MaxGrid], green_acc[MaxGrid], blue_acc[MaxGrid], alpha_acc[MaxGrid];
    int unsigned src_col, src_row, grid_col, grid_row, col_num, row_num;

    avg_cell_t   expected_cells[$];
    int          src_idle_pct = 37, dst_idle_pct = 49;
    int unsigned cycle_count = 0;
    bit          failed = 1'b0;

    area_average_downscale dut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        avg_cell_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected cell beat %h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                e = expected_cells.pop_front();
                if (m_tdata[5:0] !== e.x)
                begin
                    $error("cell_x exp %0d got %0d", e.x, m_tdata[5:0]); failed = 1'b1;
                end
                if (m_tdata[11:6] !== e.y)
                begin
                    $error("cell_y exp %0d got %0d", e.y, m_tdata[11:6]); failed = 1'b1;
                end
                if (m_tdata[19:12] !== e.r)
                begin
                    $error("red_avg exp %0d got %0d", e.r, m_tdata[19:12]); failed = 1'b1;
                end
                if (m_tdata[27:20] !== e.g)
                begin
                    $error("green_avg exp %0d got %0d", e.g, m_tdata[27:20]); failed = 1'b1;
                end
                if (m_tdata[35:28] !== e.b)
                begin
                    $error("blue_avg exp %0d got %0d", e.b, m_tdata[35:28]); failed = 1'b1;
                end
                if (m_tdata[43:36] !== e.a)
                begin
                    $error("alpha_avg exp %0d got %0d", e.a, m_tdata[43:36]); failed = 1'b1;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_of_frame exp %0d got %0d", e.last, m_tlast); failed = 1'b1;
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        src_col = 0; src_row = 0; grid_col = 0; grid_row = 0; col_num = 0; row_num = 0;
    endfunction

    // bit-exact cell averaging for one accepted pixel
    task automatic average_pixel(input bit fs, input logic [7:0] r, g, b, a_in,
                                 output bit done, output avg_cell_t res);
        int unsigned w, h, n, cs, ce, rs, re, idx, cnt;
        bit band;
        logic [7:0] a;
        w = clamp_dim(reg_width, MaxSource);
        h = clamp_dim(reg_height, MaxSource);
        n = clamp_dim(reg_grid, MaxGrid);
        a = reg_alpha ? a_in : FullAlpha;
        done = 1'b0;
        if (n > w) n = w;
        if (n > h) n = h;
        if (fs) restart_frame();
        cs = col_num / n; ce = (col_num + w) / n;
        rs = row_num / n; re = (row_num + h) / n;
        band = (src_row == rs);
        idx = grid_col % MaxGrid;
        red_acc[idx]   = band ? SumW'(r) : red_acc[idx] + r;
        green_acc[idx] = band ? SumW'(g) : green_acc[idx] + g;
        blue_acc[idx]  = band ? SumW'(b) : blue_acc[idx] + b;
        alpha_acc[idx] = band ? SumW'(a) : alpha_acc[idx] + a;
        if (src_col + 1 == ce && src_row + 1 == re)
        begin
            cnt = (ce - cs) * (re - rs);
            if (cnt == 0) cnt = 1;
            res.x = grid_col[5:0];
            res.y = grid_row[5:0];
            res.r = 8'(red_acc[idx] / cnt);
            res.g = 8'(green_acc[idx] / cnt);
            res.b = 8'(blue_acc[idx] / cnt);
            res.a = 8'(alpha_acc[idx] / cnt);
            res.last = (grid_col + 1 == n && grid_row + 1 == n);
            done = 1'b1;
        end
        // advance position
        if (src_col + 1 >= w)
        begin
            src_col = 0; grid_col = 0; col_num = 0;
            if (src_row + 1 >= h)
            begin
                src_row = 0; grid_row = 0; row_num = 0;
            end
            else
            begin
                if (src_row + 1 == re)
                begin
                    grid_row++;
                    row_num += h;
                end
                src_row++;
            end
        end
        else
        begin
            if (src_col + 1 == ce)
            begin
                grid_col++;
                col_num += w;
            end
            src_col++;
        end
    endtask

    // one pixel beat with random source gaps; returns the predicted cell
    task automatic send_pixel(input bit fs, input logic [7:0] r, g, b, a,
                              output bit done, output avg_cell_t res);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fs;
        s_tdata  <= {a, b, g, r};
        do @(posedge clk); while (!s_tready);
        average_pixel(fs, r, g, b, a, done, res);
    endtask

    task automatic send_random(input bit fs);
        bit done;
        avg_cell_t res;
        send_pixel(fs, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), done, res);
        if (done) expected_cells.push_back(res);
    endtask

    // wait for every cell, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_cells.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [10:0] value);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= index; cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_WIDTH:  reg_width  = value;
            REG_HEIGHT: reg_height = value;
            REG_SIZE:   reg_grid   = value[6:0];
            REG_ALPHA:  reg_alpha  = value[0];
            default:    ;
        endcase
        restart_frame();
    endtask

    task automatic set_format(input logic [10:0] w, h, n, input bit alpha_on);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SIZE, n);
        write_reg(REG_ALPHA, {10'd0, alpha_on});
    endtask

    // directed pixels on a 1x1 source with zero and oversized registers:
    // every pixel is its own cell, so the average is the pixel itself, with alpha full while alpha is off
    pixel_row_t pixel_rows[] = '{
        '{1, 1, 8'h00, 8'h00, 8'h00, 8'h00, 1},
        '{1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1},
        '{1, 0, 8'hAA, 8'h55, 8'hAA, 8'h55, 1},
        '{1, 1, 8'h55, 8'hAA, 8'h55, 8'hAA, 1},
        '{1, 0, 8'h01, 8'h80, 8'h7F, 8'hFE, 1},
        '{1, 0, 8'hFF, 8'h00, 8'hFF, 8'h00, 0},
        '{1, 1, 8'h12, 8'h34, 8'h56, 8'h78, 0},
        '{0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1},
        '{0, 1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1},
        '{0, 0, 8'h9C, 8'h3E, 8'hD1, 8'h42, 0},
        '{0, 0, 8'h07, 8'hE0, 8'h81, 8'h18, 1}
    };

    initial
    begin
        int sent, phase, pick, pixels, wd, ht;
        bit done, alpha_now;
        avg_cell_t res;
        logic [10:0] w, h, n;

        restart_frame();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset format: a few pixels, none finishes a cell
        repeat (6) send_random(1'($urandom_range(1)));
        drain();

        // directed table
        alpha_now = 1'b1;
        set_format(11'd0, 11'd0, 11'd127, alpha_now);
        foreach (pixel_rows[i])
        begin
            if (pixel_rows[i].alpha_on != alpha_now)
            begin
                drain();
                alpha_now = pixel_rows[i].alpha_on;
                write_reg(REG_ALPHA, {10'd0, alpha_now});
            end
            send_pixel(pixel_rows[i].fs, pixel_rows[i].r, pixel_rows[i].g,
                       pixel_rows[i].b, pixel_rows[i].a, done, res);
            if (pixel_rows[i].typed)
                expected_cells.push_back('{6'd0, 6'd0, pixel_rows[i].r, pixel_rows[i].g,
                    pixel_rows[i].b, alpha_now ? pixel_rows[i].a : FullAlpha, 1'b1});
            else if (done)
                expected_cells.push_back(res);
        end
        drain();

        // random phases, each under a fresh format
        sent = 0;
        phase = 0;
        while (phase < 9 || sent < 750)
        begin
            if (sent >= 500)
            begin
                src_idle_pct = 0; dst_idle_pct = 0;
            end
            else if (sent >= 250)
            begin
                src_idle_pct = 49; dst_idle_pct = 37;
            end
            pick = (phase == 2) ? 0 : (phase == 5) ? 1 : (phase == 8) ? 2 : 3;
            case (pick)
                0:
                begin
                    w = 11'd2047; h = 11'd1; n = 11'd127;
                end
                1:
                begin
                    w = 11'd1; h = 11'd2047; n = 11'd0;
                end
                2:
                begin
                    w = 11'd64; h = 11'd64; n = 11'd64;
                end
                default:
                begin
                    w = 11'($urandom_range(12));
                    h = 11'($urandom_range(12));
                    n = ($urandom_range(7) == 0) ? 11'd127 : 11'($urandom_range(15));
                end
            endcase
            set_format(w, h, n, 1'($urandom_range(1)));
            wd = clamp_dim(w, MaxSource);
            ht = clamp_dim(h, MaxSource);
            pixels = (pick == 2) ? 150 : (pick < 2) ? 64 : wd * ht * $urandom_range(1, 2);
            // random formats send whole frames; first pixels marked at random; some stray frame starts
            for (int k = 0; k < pixels; k++)
            begin
                if ($urandom_range(99) < 3)
                    send_random(1'b1);
                else
                    send_random((k % (wd * ht) == 0) ? 1'($urandom_range(1)) : 1'b0);
                sent++;
            end
            drain();
            phase++;
        end

        if (!failed)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

>>> area_average_downscale.f
+incdir+hw/rtl
hw/rtl/aad_pkg.sv
hw/rtl/aad_ram.sv
hw/rtl/aad_divider.sv
hw/rtl/area_average_downscale.sv
verif/testbench.sv
